// ===== hdl/bsm_pkg.sv =====
// Shared constants and controller-to-datapath command type for the Booth multiplier.
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    // Fixed field widths of the ports
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;

    // Default operand width of the datapath
    localparam int WIDTH_DEF = 16;

    // Booth recoding pairs {Q[0], q_1}
    localparam logic [1:0] PAIR_ADD = 2'b01;
    localparam logic [1:0] PAIR_SUB = 2'b10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture operands, clear accumulator and extra bit
        logic step;     // one add/subtract and arithmetic shift
        logic capture;  // move the finished product into the output register
    } bsm_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/booth_signed_multiplier.sv =====
// Top level of the sequential radix-2 Booth signed multiplier.
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 Booth multiplier for two's-complement operands. A transaction on the
// request channel carries multiplicand and multiplier; one transaction on the
// response channel returns their signed product. Each operation loads the
// operands, runs WIDTH add/subtract-and-shift iterations of the single
// accumulator adder and moves the product into the output register once
// that register is free or being emptied. The request channel
// stalls while an operation is in progress; a finished product waits in the
// output register, so the next operation can start while the response is
// still stalled. Operands are sign-extended and then cut to WIDTH bits; the
// 2*WIDTH-bit product is cut or zero-extended to the 32-bit product port.

module booth_signed_multiplier
    import bsm_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic signed [IN_W-1:0] multiplicand,
    input  wire logic signed [IN_W-1:0] multiplier,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic signed [OUT_W-1:0]     product
);

    bsm_cmd_t cmd;

    // Sequencer
    bsm_ctrl #(
        .WIDTH     (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Accumulator, shift registers and output register
    bsm_datapath #(
        .WIDTH        (WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .product      (product)
    );

endmodule

`default_nettype wire

// ===== hdl/bsm_datapath.sv =====
// Booth datapath: operand, accumulator and multiplier registers plus output register.
`timescale 1ns / 1ps
`default_nettype none

module bsm_datapath
    import bsm_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire bsm_cmd_t                cmd,
    input  wire logic signed [IN_W-1:0]  multiplicand,
    input  wire logic signed [IN_W-1:0]  multiplier,
    output logic signed [OUT_W-1:0]      product
);

    localparam int EXT_W = (WIDTH > IN_W) ? WIDTH : IN_W;
    localparam int PW    = 2 * WIDTH;
    localparam int PE_W  = (PW > OUT_W) ? PW : OUT_W;

    logic [WIDTH-1:0]  m_reg;
    logic [WIDTH:0]    a_reg;
    logic [WIDTH-1:0]  q_reg;
    logic              q1_reg;
    logic [OUT_W-1:0]  product_reg;

    logic [EXT_W-1:0]  mcand_ext;
    logic [EXT_W-1:0]  mplier_ext;
    logic [WIDTH:0]    m_wide;
    logic [WIDTH:0]    a_sum;
    logic [PW-1:0]     prod_full;
    logic [PE_W-1:0]   prod_ext;

    // Sign-extend the operand fields, then keep the low WIDTH bits
    assign mcand_ext  = EXT_W'(multiplicand);
    assign mplier_ext = EXT_W'(multiplier);

    // Multiplicand widened by one bit so the most negative value subtracts cleanly
    assign m_wide = {m_reg[WIDTH-1], m_reg};

    // Add, subtract or hold according to the recoding pair
    always_comb
    begin
        case ({q_reg[0], q1_reg})
            PAIR_ADD: a_sum = a_reg + m_wide;
            PAIR_SUB: a_sum = a_reg - m_wide;
            default:  a_sum = a_reg;
        endcase
    end

    // Product is A (low WIDTH bits) then Q, zero-extended or cut to the port
    assign prod_full = {a_reg[WIDTH-1:0], q_reg};
    assign prod_ext  = PE_W'(prod_full);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg  <= mcand_ext[WIDTH-1:0];
            q_reg  <= mplier_ext[WIDTH-1:0];
            a_reg  <= '0;
            q1_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            q1_reg <= q_reg[0];
            q_reg  <= {a_sum[0], q_reg[WIDTH-1:1]};
            a_reg  <= {a_sum[WIDTH], a_sum[WIDTH:1]};
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            product_reg <= prod_ext[OUT_W-1:0];
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== hdl/bsm_ctrl.sv =====
// Booth controller: sequences load, WIDTH steps and output capture; owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module bsm_ctrl
    import bsm_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output bsm_cmd_t  cmd
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             out_free;

    // Output slot can take a product when empty or being emptied this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== test/booth_signed_multiplier_tb.sv =====
// Self-checking testbench for the radix-2 Booth signed multiplier.
`timescale 1ns / 1ps

module booth_signed_multiplier_tb;
    import bsm_pkg::*;

    localparam int WIDTH       = WIDTH_DEF;
    localparam int RANDOM_OPS  = 750;
    localparam int SETTLE_CYC  = 2 * (WIDTH + 2) + 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [IN_W-1:0] mcand;
        logic signed [IN_W-1:0] mplier;
        int                     gap;    // idle cycles before this transaction
        bit                     drain;  // hold off until all products are back
    } mult_op_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    req_valid    = 1'b0;
    logic                    req_stall;
    logic signed [IN_W-1:0]  multiplicand = '0;
    logic signed [IN_W-1:0]  multiplier   = '0;
    logic                    rsp_valid;
    logic                    rsp_stall    = 1'b0;
    logic signed [OUT_W-1:0] product;

    mult_op_t                pending_ops[$];
    logic signed [OUT_W-1:0] expected_products[$];
    int                      gap_left;
    int                      stall_left;
    int                      quiet_left;
    int                      mismatch_count;
    int                      cycle_count;

    booth_signed_multiplier #(.WIDTH(WIDTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .product      (product)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Booth product: WIDTH add/subtract-and-shift steps over a wide accumulator
    function automatic logic signed [OUT_W-1:0] booth_product(
        input logic signed [IN_W-1:0] mcand,
        input logic signed [IN_W-1:0] mplier
    );
        logic [63:0]      m_val;
        logic [63:0]      mq_val;
        logic [63:0]      acc;
        logic [WIDTH-1:0] q_reg;
        logic             q_extra;
        logic [127:0]     wide;
        m_val  = 64'(mcand);
        m_val  = {{(64-WIDTH){m_val[WIDTH-1]}}, m_val[WIDTH-1:0]};
        mq_val = 64'(mplier);
        q_reg  = mq_val[WIDTH-1:0];
        acc     = '0;
        q_extra = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            case ({q_reg[0], q_extra})
                PAIR_SUB: acc = acc - m_val;
                PAIR_ADD: acc = acc + m_val;
                default:  ;
            endcase
            q_extra = q_reg[0];
            q_reg   = {acc[0], q_reg[WIDTH-1:1]};
            acc     = {acc[63], acc[63:1]};
        end
        wide = ((128'(acc) << WIDTH) | 128'(q_reg)) & ((128'(1) << (2 * WIDTH)) - 1);
        return wide[OUT_W-1:0];
    endfunction

    function automatic int pick_operand();
        // bias toward the corners now and then
        case ($urandom_range(0, 9))
            0: return -(2 ** (IN_W - 1));
            1: return 2 ** (IN_W - 1) - 1;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return int'($signed(IN_W'($urandom)));
        endcase
    endfunction

    task automatic queue_op(input int mcand,
                            input int mplier,
                            input int gap, input bit drain);
        mult_op_t op;
        op.mcand  = IN_W'(mcand);
        op.mplier = IN_W'(mplier);
        op.gap    = gap;
        op.drain  = drain;
        pending_ops.push_back(op);
    endtask

    // Request driver: one transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        logic     nxt_valid;
        mult_op_t op;
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            multiplicand <= '0;
            multiplier   <= '0;
            gap_left     = -1;
        end
        else
        begin
            nxt_valid = req_valid;
            if (req_valid && !req_stall)
            begin
                expected_products.push_back(booth_product(multiplicand, multiplier));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_ops.size() > 0)
            begin
                if (gap_left < 0)
                    gap_left = pending_ops[0].gap;
                if (gap_left > 0)
                    gap_left--;
                else if (!pending_ops[0].drain || expected_products.size() == 0)
                begin
                    op = pending_ops.pop_front();
                    multiplicand <= op.mcand;
                    multiplier   <= op.mplier;
                    nxt_valid    = 1'b1;
                    gap_left     = -1;
                end
            end
            req_valid <= nxt_valid;
        end
    end

    // Response monitor: random stalls, in-order product check
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [OUT_W-1:0] want;
        if (!rst_n)
        begin
            rsp_stall      <= 1'b0;
            stall_left     = 0;
            quiet_left     = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    $display("%0t: unexpected product 0x%08h", $realtime, product);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (product !== want)
                    begin
                        $display("%0t: product expected %0d (0x%08h) actual %0d (0x%08h)",
                                 $realtime, want, want, product, product);
                        mismatch_count++;
                    end
                end
                // occasionally run a stretch of results with no backpressure
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 9) == 0)
                    quiet_left = 30;
                stall_left = (quiet_left > 0) ? 0 : $urandom_range(0, 4);
            end
            else if (stall_left > 0)
                stall_left--;
            rsp_stall <= (stall_left > 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of test
    initial
    begin
        int max_gap;
        cycle_count = 0;

        // Directed: operand corners and Booth pair patterns
        queue_op(0, 0, 0, 0);
        queue_op(-32768, -32768, 0, 0);
        queue_op(-32768, 32767, 1, 0);
        queue_op(32767, -32768, 0, 0);
        queue_op(32767, 32767, 2, 0);
        queue_op(-1, -1, 0, 0);
        queue_op(1, -1, 0, 0);
        queue_op(-1, 1, 3, 0);
        queue_op(-32768, 1, 0, 0);
        queue_op(1, -32768, 0, 0);
        queue_op(-32768, -1, 4, 0);
        queue_op(-32768, 0, 0, 0);
        queue_op(0, -32768, 0, 0);
        queue_op(21845, -21846, 1, 0);   // alternating bit patterns
        queue_op(-21846, 21845, 0, 0);
        queue_op(12345, 255, 0, 0);
        queue_op(-12345, -256, 2, 0);
        queue_op(32767, 1, 0, 0);

        // Random: stretches of back-to-back traffic and of random gaps
        max_gap = 4;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 50 == 0)
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
            queue_op(pick_operand(), pick_operand(), $urandom_range(0, max_gap),
                     (i == 0) || (i == 300) || (i == 600));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_valid || expected_products.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatch_count == 0 && expected_products.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
